[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sparse SOR row engine.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// check a property on every clock edge outside reset
`define SSOR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check a property on every clock edge, reset included
`define SSOR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SSOR_ASSERT(label, clk, rst_n, prop, msg)
`define SSOR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[design/ssor_pkg.sv]
// ---------------------------------------------------------------------------
// ssor_pkg
// Widths, codes and shared types of the sparse SOR row engine.
// ---------------------------------------------------------------------------
package ssor_pkg;

  // default geometry
  localparam int VECTOR_DEPTH_DEF  = 4096;
  localparam int FRACTION_BITS_DEF = 16;

  // fixed field widths
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 12;
  localparam int ACC_W   = 48;
  localparam int LO_W    = ACC_W / 2;
  localparam int OMEGA_W = 18;
  localparam int PROD_W  = 2 * DATA_W;

  // omega is Q2.16 whatever the data format
  localparam int                 OMEGA_FRAC = 16;
  localparam logic [OMEGA_W-1:0] OMEGA_ONE  = OMEGA_W'(65536);

  // action codes
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_ENTRY = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // result kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_RELAX = 1'b1;

  // operand pair for the shared multiplier
  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } mul_req_t;

endpackage

[design/ssor_mul.sv]
// ---------------------------------------------------------------------------
// ssor_mul
// Shared signed 32x32 multiplier with a registered full-width product.
// ---------------------------------------------------------------------------
module ssor_mul import ssor_pkg::*; (
  input  logic                     clk,
  input  mul_req_t                 req,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;

  // form the exact product
  always_comb begin
    prod_nxt = PROD_W'(req.a) * PROD_W'(req.b);
  end

  // register it
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

[design/ssor_ram.sv]
// ---------------------------------------------------------------------------
// ssor_ram
// Solution vector store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module ssor_ram import ssor_pkg::*; #(
  parameter  int DEPTH  = VECTOR_DEPTH_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/sparse_sor_row_relaxation.sv]
// ---------------------------------------------------------------------------
// sparse_sor_row_relaxation
// Sparse SOR sweep engine: vector store, row accumulator, shared multiplier.
// ---------------------------------------------------------------------------
// Usage: software loads the solution vector with write beats, then streams
// the nonzero entries of each row (first and last marks delimit a row).
// Read beats return a stored element. The input channel stalls while a beat
// is being worked on; results leave through a one-deep output register.
// Work per input beat, from acceptance until the next beat can be accepted:
//   write: the store is written; the input does not stall.
//   read: a store read; the element is then placed in the output register.
//   matrix entry, not last: store read, multiply, accumulate.
//   matrix entry, last: as above, then the row update; the single shared
//   32x32 multiplier is used four times in turn (coefficient, 1-omega term,
//   low and high halves of the accumulator) and the store is read twice.
// The result register holds its beat while out_stall is high; a result that
// finds it still full waits, and the input stays stalled meanwhile.
// Reset (rst_n low, synchronous) sets omega to 1.0, clears the accumulator
// and drops any pending result. The store is not cleared: elements must be
// written before they are read. VECTOR_DEPTH is expected to be a power of
// two; indices wrap on its low bits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sparse_sor_row_relaxation import ssor_pkg::*; #(
  parameter int VECTOR_DEPTH  = VECTOR_DEPTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     cfg_wr_en,
  input  logic [OMEGA_W-1:0]       cfg_wr_data,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_action,
  input  logic [IDX_W-1:0]         in_row_index,
  input  logic [IDX_W-1:0]         in_column_index,
  input  logic signed [DATA_W-1:0] in_item_value,
  input  logic signed [DATA_W-1:0] in_rhs_value,
  input  logic signed [DATA_W-1:0] in_inv_diag_scaled,
  input  logic                     in_first_in_row,
  input  logic                     in_last_in_row,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_index,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_kind,
  output logic                     out_saturated
);

  localparam int ADDR_W = $clog2(VECTOR_DEPTH);
  localparam int DIFF_W = PROD_W + 2;
  localparam int T1_W   = DATA_W + OMEGA_W + 2 - OMEGA_FRAC;
  localparam int SUM_W  = PROD_W + LO_W;

  localparam logic signed [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_ACC  = 8'b0000_0100,
    S_T1   = 8'b0000_1000,
    S_LO   = 8'b0001_0000,
    S_HI   = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_RD   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration and row state
  logic [OMEGA_W-1:0]       relax_r, relax_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;

  // latched entry
  logic [IDX_W-1:0]         row_r, row_nxt;
  logic signed [DATA_W-1:0] item_r, item_nxt;
  logic signed [DATA_W-1:0] inv_r, inv_nxt;
  logic                     last_r, last_nxt;
  logic                     diag_r, diag_nxt;

  // update terms
  logic signed [T1_W-1:0]   t1_r, t1_nxt;
  logic signed [PROD_W-1:0] part_r, part_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;

  // result register
  logic                     out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]         out_index_r, out_index_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic                     out_kind_r, out_kind_nxt;
  logic                     out_sat_r, out_sat_nxt;

  // store and multiplier hookup
  logic                     wr_en, rd_en;
  logic [ADDR_W-1:0]        wr_addr, rd_addr;
  logic [DATA_W-1:0]        wr_data;
  logic signed [DATA_W-1:0] rd_data;
  mul_req_t                 mul_req;
  logic signed [PROD_W-1:0] prod;

  // arithmetic helpers
  logic                     accept;
  logic                     out_free;
  logic signed [OMEGA_W:0]  omc;
  logic signed [LO_W-1:0]   acc_hi;
  logic signed [DIFF_W-1:0] diff;
  logic signed [SUM_W-1:0]  relaxed;
  logic signed [DATA_W-1:0] relaxed_sat;
  logic                     relaxed_clip;

  ssor_ram #(
    .DEPTH   (VECTOR_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ssor_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // 1 - omega as a signed Q2.16 factor, high half of the accumulator
  assign omc    = $signed({1'b0, OMEGA_ONE}) - $signed({1'b0, relax_r});
  assign acc_hi = acc_r[ACC_W-1:LO_W];

  // accumulator minus floored product
  assign diff = DIFF_W'(acc_r) - DIFF_W'(prod >>> FRACTION_BITS);

  // relaxed value and its clip to the data range
  always_comb begin
    relaxed      = (sum_r >>> FRACTION_BITS) + SUM_W'(t1_r);
    relaxed_clip = 1'b0;
    relaxed_sat  = DATA_W'(relaxed);
    if (relaxed > SUM_W'(DATA_MAX)) begin
      relaxed_sat  = DATA_MAX;
      relaxed_clip = 1'b1;
    end else if (relaxed < SUM_W'(DATA_MIN)) begin
      relaxed_sat  = DATA_MIN;
      relaxed_clip = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    relax_nxt     = relax_r;
    acc_nxt       = acc_r;
    row_nxt       = row_r;
    item_nxt      = item_r;
    inv_nxt       = inv_r;
    last_nxt      = last_r;
    diag_nxt      = diag_r;
    t1_nxt        = t1_r;
    part_nxt      = part_r;
    sum_nxt       = sum_r;
    out_index_nxt = out_index_r;
    out_value_nxt = out_value_r;
    out_kind_nxt  = out_kind_r;
    out_sat_nxt   = out_sat_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr_en         = 1'b0;
    wr_addr       = ADDR_W'(in_row_index);
    wr_data       = in_item_value;
    rd_en         = 1'b0;
    rd_addr       = ADDR_W'(in_row_index);
    mul_req.a     = '0;
    mul_req.b     = '0;

    if (cfg_wr_en) begin
      relax_nxt = cfg_wr_data;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          row_nxt  = in_row_index;
          item_nxt = in_item_value;
          inv_nxt  = in_inv_diag_scaled;
          last_nxt = in_last_in_row;
          diag_nxt = (in_column_index == in_row_index);
          case (in_action)
            ACT_WRITE: begin
              wr_en = 1'b1;
            end
            ACT_ENTRY: begin
              rd_en   = 1'b1;
              rd_addr = ADDR_W'(in_column_index);
              if (in_first_in_row) begin
                acc_nxt = ACC_W'(in_rhs_value);
              end
              state_nxt = S_MUL;
            end
            ACT_READ: begin
              rd_en     = 1'b1;
              state_nxt = S_RD;
            end
            default: begin
              // unused action: drop
            end
          endcase
        end
      end
      S_MUL: begin
        // coefficient times column value; fetch the row's old value
        mul_req.a = item_r;
        mul_req.b = rd_data;
        rd_en     = 1'b1;
        rd_addr   = ADDR_W'(row_r);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (!diag_r) begin
          if (diff > DIFF_W'(ACC_MAX)) begin
            acc_nxt = ACC_MAX;
          end else if (diff < DIFF_W'(ACC_MIN)) begin
            acc_nxt = ACC_MIN;
          end else begin
            acc_nxt = ACC_W'(diff);
          end
        end
        // old value times (1 - omega)
        mul_req.a = rd_data;
        mul_req.b = DATA_W'(omc);
        state_nxt = last_r ? S_T1 : S_IDLE;
      end
      S_T1: begin
        t1_nxt    = T1_W'(prod >>> OMEGA_FRAC);
        mul_req.a = inv_r;
        mul_req.b = $signed({{(DATA_W-LO_W){1'b0}}, acc_r[LO_W-1:0]});
        state_nxt = S_LO;
      end
      S_LO: begin
        part_nxt  = prod;
        mul_req.a = inv_r;
        mul_req.b = DATA_W'(acc_hi);
        state_nxt = S_HI;
      end
      S_HI: begin
        sum_nxt   = (SUM_W'(prod) <<< LO_W) + SUM_W'(part_r);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // store and emit once the result register is free
        if (out_free) begin
          wr_en         = 1'b1;
          wr_addr       = ADDR_W'(row_r);
          wr_data       = relaxed_sat;
          out_valid_nxt = 1'b1;
          out_index_nxt = row_r;
          out_value_nxt = relaxed_sat;
          out_kind_nxt  = KIND_RELAX;
          out_sat_nxt   = relaxed_clip;
          state_nxt     = S_IDLE;
        end
      end
      S_RD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = row_r;
          out_value_nxt = rd_data;
          out_kind_nxt  = KIND_READ;
          out_sat_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      relax_r     <= OMEGA_ONE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      relax_r     <= relax_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    row_r       <= row_nxt;
    item_r      <= item_nxt;
    inv_r       <= inv_nxt;
    last_r      <= last_nxt;
    diag_r      <= diag_nxt;
    t1_r        <= t1_nxt;
    part_r      <= part_nxt;
    sum_r       <= sum_nxt;
    out_index_r <= out_index_nxt;
    out_value_r <= out_value_nxt;
    out_kind_r  <= out_kind_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_index     = out_index_r;
  assign out_value     = out_value_r;
  assign out_kind      = out_kind_r;
  assign out_saturated = out_sat_r;

  // a clipped result is a relaxed row value at one end of the range
  `SSOR_ASSERT(a_sat_kind, clk, rst_n, (out_valid && out_saturated) |-> (out_kind == KIND_RELAX), "saturated flag on read data")
  `SSOR_ASSERT(a_sat_value, clk, rst_n, (out_valid && out_saturated) |-> (out_value == DATA_MAX || out_value == DATA_MIN), "saturated value not at range limit")
  // entry and read beats keep the input stalled after they are accepted
  `SSOR_ASSERT(a_busy_after_accept, clk, rst_n, (accept && (in_action == ACT_ENTRY || in_action == ACT_READ)) |=> in_stall, "input taken while sequencer busy")
  // the update path is entered only for a row's last entry
  `SSOR_ASSERT(a_update_last, clk, rst_n, (state_r == S_T1) |-> last_r, "row update without last mark")

endmodule
